### hw/rtl/rhc_pkg.sv
// Shared definitions for the RGB to HSV converter: default widths,
// the controller state type, the hue sector codes and the divider status struct.
// No dependencies.
`default_nettype none

package rhc_pkg;

    // Default field widths.
    localparam int COMPONENT_BITS_DEF = 8;
    localparam int FRACTION_BITS_DEF  = 16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } t_state;

    // Sector that holds the largest component.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Status that a serial divider reports to the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

### hw/rtl/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: request handshakes, color compare,
// sector selection and result assembly. Depends on rhc_pkg and rhc_div.
`default_nettype none

// A request carries one red, green and blue sample. If it matches the last
// stored color, the held hue, saturation and brightness come back with changed
// low after the request passes the compare and done states. For a new color,
// the maximum, minimum and sector are found and the dividers started, then
// the two bit-serial dividers run side by side for saturation and hue, the
// controller sees them finish, and the result is assembled into the output
// register. One request is worked on at a time; a finished result sits in
// the output register, so the next request is taken while it waits. Black
// keeps the held hue and saturation, and gray keeps the held hue.
module rgb_to_hsv_converter_unit #(
    parameter int COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = rhc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [COMPONENT_BITS-1:0] i_red,
    input  wire logic [COMPONENT_BITS-1:0] i_green,
    input  wire logic [COMPONENT_BITS-1:0] i_blue,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [FRACTION_BITS+2:0]       o_hue,
    output logic [FRACTION_BITS:0]         o_saturation,
    output logic [COMPONENT_BITS-1:0]      o_brightness,
    output logic                           o_changed
);
    import rhc_pkg::*;

    localparam int C_W   = COMPONENT_BITS;
    localparam int HUE_W = FRACTION_BITS + 3;
    localparam int Q_W   = FRACTION_BITS + 1;
    localparam logic [HUE_W-1:0] HUE_TWO  = HUE_W'(2) << FRACTION_BITS;
    localparam logic [HUE_W-1:0] HUE_FOUR = HUE_W'(4) << FRACTION_BITS;
    localparam logic [HUE_W-1:0] HUE_SIX  = HUE_W'(6) << FRACTION_BITS;
    localparam logic [Q_W-1:0]   SAT_ONE  = Q_W'(1) << FRACTION_BITS;

    t_state           r_state, n_state;
    logic [C_W-1:0]   r_red, r_green, r_blue;
    logic [C_W-1:0]   r_last_red, r_last_green, r_last_blue;
    logic             r_changed, r_neg, r_upd_hue, r_upd_sat;
    t_sector          r_sector;
    logic [C_W-1:0]   r_bright;
    logic [HUE_W-1:0] r_held_hue;
    logic [Q_W-1:0]   r_held_sat;
    logic [C_W-1:0]   r_held_bright;
    logic             r_out_changed;
    logic             r_out_valid;

    logic             in_accept, out_free, out_load, div_start;
    logic             changed_c, neg_c;
    logic [C_W-1:0]   mx_c, mn_c, mag_c;
    t_sector          sector_c;
    t_div_sts         sat_sts, hue_sts;
    logic [Q_W-1:0]   sat_q, hue_q;
    logic [HUE_W-1:0] hue_base, hue_q_ext, n_hue;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CMP;
            ST_CMP:  n_state = changed_c ? ST_DIV : ST_DONE;
            ST_DIV:  if (sat_sts.done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_CMP:  div_start  = changed_c;
            ST_DIV:  ;
            ST_DONE: out_load   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // Compare with the stored color, find max, min, sector and difference.
    always_comb begin
        changed_c = (r_red != r_last_red) || (r_green != r_last_green) ||
                    (r_blue != r_last_blue);
        mx_c = (r_red > r_green) ? r_red : r_green;
        mn_c = (r_red < r_green) ? r_red : r_green;
        if (r_blue > mx_c) mx_c = r_blue;
        if (r_blue < mn_c) mn_c = r_blue;
        priority if (mx_c == r_red) begin
            sector_c = SEC_RED;
            neg_c    = (r_green < r_blue);
            mag_c    = neg_c ? (r_blue - r_green) : (r_green - r_blue);
        end else if (mx_c == r_green) begin
            sector_c = SEC_GREEN;
            neg_c    = (r_blue < r_red);
            mag_c    = neg_c ? (r_red - r_blue) : (r_blue - r_red);
        end else begin
            sector_c = SEC_BLUE;
            neg_c    = (r_red < r_green);
            mag_c    = neg_c ? (r_green - r_red) : (r_red - r_green);
        end
    end

    // Stored color and per-request flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_red   <= '0;
            r_last_green <= '0;
            r_last_blue  <= '0;
            r_changed    <= 1'b0;
        end else if (r_state == ST_CMP) begin
            r_changed <= changed_c;
            if (changed_c) begin
                r_last_red   <= r_red;
                r_last_green <= r_green;
                r_last_blue  <= r_blue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CMP) begin
            r_sector  <= sector_c;
            r_neg     <= neg_c;
            r_bright  <= mx_c;
            r_upd_sat <= (mx_c != '0);
            r_upd_hue <= (mx_c != mn_c);
        end
    end

    // Saturation divider: min / max.
    rhc_div #(
        .DEN_W (C_W),
        .Q_W   (Q_W)
    ) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mn_c),
        .i_den   (mx_c),
        .o_sts   (sat_sts),
        .o_quot  (sat_q)
    );

    // Hue divider: |difference| / (max - min).
    rhc_div #(
        .DEN_W (C_W),
        .Q_W   (Q_W)
    ) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag_c),
        .i_den   (mx_c - mn_c),
        .o_sts   (hue_sts),
        .o_quot  (hue_q)
    );

    // Hue assembly. A negative red-sector hue wraps by six sixths, except
    // when the quotient is zero.
    always_comb begin
        hue_q_ext = HUE_W'(hue_q);
        unique case (r_sector)
            SEC_RED:   hue_base = (r_neg && hue_q != '0) ? HUE_SIX : '0;
            SEC_GREEN: hue_base = HUE_TWO;
            SEC_BLUE:  hue_base = HUE_FOUR;
            default:   hue_base = '0;
        endcase
        n_hue = r_neg ? (hue_base - hue_q_ext) : (hue_base + hue_q_ext);
    end

    // Held results, which also serve as the output payload. The changed flag
    // is copied out so that the next request cannot disturb a waiting result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_hue    <= '0;
            r_held_sat    <= '0;
            r_held_bright <= '0;
            r_out_changed <= 1'b0;
        end else if (out_load) begin
            r_out_changed <= r_changed;
            if (r_changed) begin
                r_held_bright <= r_bright;
                if (r_upd_sat) r_held_sat <= SAT_ONE - sat_q;
                if (r_upd_sat && r_upd_hue) r_held_hue <= n_hue;
            end
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hue        = r_held_hue;
    assign o_saturation = r_held_sat;
    assign o_brightness = r_held_bright;
    assign o_changed    = r_out_changed;

    // The two dividers always run in lock step.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sat_sts == hue_sts)
        else $error("saturation and hue dividers out of step");

    // While waiting on the dividers, they are working or just finished.
    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (sat_sts.busy || sat_sts.done))
        else $error("waiting on an idle divider");

    // A repeated color leaves the held results untouched.
    a_hold_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_changed) |=>
            ($stable(r_held_hue) && $stable(r_held_sat) && $stable(r_held_bright)))
        else $error("held results changed for a repeated color");

    // Saturation never exceeds one.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_sat <= SAT_ONE)
        else $error("saturation out of range");

endmodule

`default_nettype wire

### hw/rtl/rhc_div.sv
// Bit-serial restoring divider for fractions num/den with num <= den.
// Produces one quotient bit per cycle, MSB first. Depends on rhc_pkg.
`default_nettype none

module rhc_div #(
    parameter int DEN_W = rhc_pkg::COMPONENT_BITS_DEF,
    parameter int Q_W   = rhc_pkg::FRACTION_BITS_DEF + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DEN_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output rhc_pkg::t_div_sts     o_sts,
    output logic      [Q_W-1:0]   o_quot
);
    import rhc_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;

    logic             ge;
    logic [DEN_W:0]   n_rem;

    // One restoring step: compare, and subtract when it fits; the register below shifts left.
    always_comb begin
        ge    = (r_rem >= {1'b0, r_den});
        n_rem = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(Q_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= {n_rem[DEN_W-1:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], ge};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

`default_nettype wire
